// File: rtl/core/reol_pkg.sv
// ----------------------------------------------------------------------------
// Ring entry offset lookup package
// Request and response types, request codes, state codes and defaults.
// ----------------------------------------------------------------------------
package reol_pkg;

  localparam int RING_DEPTH_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 16;
  localparam int POS_W    = 20;
  localparam int OFS_W    = 16;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] entry_handle;
    logic [LEN_W-1:0]    entry_length;
    logic [POS_W-1:0]    byte_position;
  } reol_req_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic [OFS_W-1:0]    offset_in_entry;
    logic                dropped;
    logic [HANDLE_W-1:0] dropped_handle;
  } reol_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_DONE
  } reol_state_t;

endpackage

// File: rtl/core/reol_req_if.sv
// ----------------------------------------------------------------------------
// Ring entry offset lookup request channel
// Valid/ready channel carrying one add or find request.
// ----------------------------------------------------------------------------
interface reol_req_if
  import reol_pkg::*;
  ();

  logic      valid;
  logic      ready;
  reol_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// File: rtl/core/reol_rsp_if.sv
// ----------------------------------------------------------------------------
// Ring entry offset lookup response channel
// Valid/ready channel carrying one response per request.
// ----------------------------------------------------------------------------
interface reol_rsp_if
  import reol_pkg::*;
  ();

  logic      valid;
  logic      ready;
  reol_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// File: rtl/core/ring_entry_offset_lookup_top.sv
// ----------------------------------------------------------------------------
// Ring entry offset lookup
// Ring of handle/length entries. Add writes at the write slot and drops the
// oldest entry when full; find walks from the oldest entry to the entry
// holding a byte position.
//
//   channel   dir   handshake              payload
//   in_req    in    valid/ready            reol_req_t
//   out_rsp   out   valid/ready            reol_rsp_t
//
// Add: write and handle read on accept, then ADD, then DONE (response).
// Find: WALK scans up to RING_DEPTH entries, one memory
//   read per entry through the single read port of the entry memories.
// Reset clears the state, slot pointers, full flag and output valid; entry
//   memories are not cleared, and an unwritten entry's read value is unused.
// A response waits in the output register while the next request is taken;
//   a finished response holds in DONE until the output register is free.
// ----------------------------------------------------------------------------
module ring_entry_offset_lookup_top
  import reol_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  reol_req_if.sink    in_req,
  reol_rsp_if.source  out_rsp
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W = (LENGTH_BITS > POS_W) ? LENGTH_BITS : POS_W;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    logic [AW-1:0] r;
    if (s == AW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + AW'(1);
    end
    return r;
  endfunction

  logic [HANDLE_W-1:0]    handle_mem [RING_DEPTH];
  logic [LENGTH_BITS-1:0] length_mem [RING_DEPTH];

  reol_state_t         state_r, state_nxt;
  logic [AW-1:0]       wr_slot_r, wr_slot_nxt;
  logic [AW-1:0]       old_slot_r, old_slot_nxt;
  logic                full_r, full_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  reol_rsp_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  reol_rsp_t           out_data_r, out_data_nxt;
  logic [HANDLE_W-1:0] rd_handle_r;
  logic [LENGTH_BITS-1:0] rd_len_r;

  logic                mem_we;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                in_fire;
  logic                out_free;
  logic [CNT_W-1:0]    stored_cnt;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    len_ext;
  logic [CMP_W-1:0]    pos_diff;

  assign in_req.ready  = (state_r == ST_IDLE);
  assign in_fire       = in_req.valid && in_req.ready;
  assign out_free      = !out_valid_r || out_rsp.ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  assign pos_ext  = CMP_W'(pos_r);
  assign len_ext  = CMP_W'(rd_len_r);
  assign pos_diff = pos_ext - len_ext;

  always_comb begin
    if (full_r) begin
      stored_cnt = CNT_W'(RING_DEPTH);
    end else if (wr_slot_r >= old_slot_r) begin
      stored_cnt = CNT_W'(wr_slot_r) - CNT_W'(old_slot_r);
    end else begin
      stored_cnt = CNT_W'(RING_DEPTH) - CNT_W'(old_slot_r) + CNT_W'(wr_slot_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wr_slot_nxt   = wr_slot_r;
    old_slot_nxt  = old_slot_r;
    full_nxt      = full_r;
    slot_nxt      = slot_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = wr_slot_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          if (in_req.data.req_type == REQ_ADD) begin
            mem_we          = 1'b1;
            rd_en           = 1'b1;
            rd_addr         = wr_slot_r;
            res_nxt.dropped = full_r;
            if (full_r) begin
              old_slot_nxt = next_slot(old_slot_r);
            end
            wr_slot_nxt = next_slot(wr_slot_r);
            full_nxt    = (next_slot(wr_slot_r) == old_slot_nxt);
            state_nxt   = ST_ADD;
          end else begin
            pos_nxt  = in_req.data.byte_position;
            rem_nxt  = stored_cnt;
            slot_nxt = old_slot_r;
            if (stored_cnt == '0) begin
              state_nxt = ST_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = old_slot_r;
              state_nxt = ST_WALK;
            end
          end
        end
      end
      ST_ADD: begin
        res_nxt.dropped_handle = res_r.dropped ? rd_handle_r : '0;
        state_nxt              = ST_DONE;
      end
      ST_WALK: begin
        if (pos_ext < len_ext) begin
          res_nxt.hit             = 1'b1;
          res_nxt.found_handle    = rd_handle_r;
          res_nxt.offset_in_entry = pos_r[OFS_W-1:0];
          state_nxt               = ST_DONE;
        end else begin
          pos_nxt = pos_diff[POS_W-1:0];
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            slot_nxt = next_slot(slot_r);
            rem_nxt  = rem_r - CNT_W'(1);
            rd_en    = 1'b1;
            rd_addr  = next_slot(slot_r);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      handle_mem[wr_slot_r] <= in_req.data.entry_handle;
      length_mem[wr_slot_r] <= LENGTH_BITS'(32'(in_req.data.entry_length));
    end
    if (rd_en) begin
      rd_handle_r <= handle_mem[rd_addr];
      rd_len_r    <= length_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_slot_r   <= '0;
      old_slot_r  <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_slot_r   <= wr_slot_nxt;
      old_slot_r  <= old_slot_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_full_slots: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wr_slot_r == old_slot_r))
    else $error("full ring with write slot apart from oldest slot");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_slot_r < AW'(RING_DEPTH - 1) || wr_slot_r == AW'(RING_DEPTH - 1)) &&
    (old_slot_r < AW'(RING_DEPTH - 1) || old_slot_r == AW'(RING_DEPTH - 1)))
    else $error("slot pointer beyond ring depth");

  a_walk_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (rem_r != '0))
    else $error("walk with no entries left to scan");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("response loaded outside DONE");

  a_hit_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.hit && out_data_r.dropped))
    else $error("response reports both hit and drop");

endmodule

// File: dv/reol_rsp_checker.sv
// ----------------------------------------------------------------------------
// Ring entry offset lookup response checker
// Watches both channels. Each accepted request updates a private copy of the
// entry ring and queues the response it must cause. Each accepted response
// is compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module reol_rsp_checker
  import reol_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  reol_req_if  req_mon,
  reol_rsp_if  rsp_mon,
  output int   errors,
  output int   pending,
  output int   adds_seen,
  output int   finds_seen,
  output int   hits_seen,
  output int   drops_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = RING_DEPTH_DEF;

  int                  wr_slot;
  int                  old_slot;
  logic                ring_full;
  logic [LEN_W-1:0]    slot_len    [DEPTH];
  logic [HANDLE_W-1:0] slot_handle [DEPTH];
  reol_rsp_t           owed_rsp [$];

  function automatic reol_rsp_t apply_to_ring(input reol_req_t r);
    reol_rsp_t      o;
    int             n;
    int             s;
    int             k;
    logic [POS_W:0] left;
    o = '0;
    if (r.req_type == REQ_ADD) begin
      if (ring_full) begin
        o.dropped        = 1'b1;
        o.dropped_handle = slot_handle[wr_slot];
        old_slot         = (old_slot + 1) % DEPTH;
      end
      slot_handle[wr_slot] = r.entry_handle;
      slot_len[wr_slot]    = r.entry_length;
      wr_slot              = (wr_slot + 1) % DEPTH;
      ring_full            = (wr_slot == old_slot);
    end else begin
      n    = ring_full ? DEPTH : (wr_slot + DEPTH - old_slot) % DEPTH;
      s    = old_slot;
      left = {1'b0, r.byte_position};
      for (k = 0; k < n; k++) begin
        if (left < slot_len[s]) begin
          o.hit             = 1'b1;
          o.found_handle    = slot_handle[s];
          o.offset_in_entry = left[OFS_W-1:0];
          break;
        end
        left = left - (POS_W+1)'(slot_len[s]);
        s    = (s + 1) % DEPTH;
      end
    end
    return o;
  endfunction

  function automatic int field_bad(input string fname, input logic [HANDLE_W-1:0] want,
                                   input logic [HANDLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    errors     = 0;
    adds_seen  = 0;
    finds_seen = 0;
    hits_seen  = 0;
    drops_seen = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    reol_rsp_t want;
    reol_rsp_t got;
    if (!rst_n) begin
      wr_slot   = 0;
      old_slot  = 0;
      ring_full = 1'b0;
      owed_rsp.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        want = apply_to_ring(req_mon.data);
        owed_rsp.push_back(want);
        if (req_mon.data.req_type == REQ_ADD) adds_seen++;
        else finds_seen++;
        if (want.hit) hits_seen++;
        if (want.dropped) drops_seen++;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (owed_rsp.size() == 0) begin
          $display("%0t: response with none outstanding, expected nothing, actual %0h",
                   $time, got);
          errors++;
        end else begin
          want = owed_rsp.pop_front();
          errors += field_bad("hit", HANDLE_W'(want.hit), HANDLE_W'(got.hit));
          errors += field_bad("found_handle", want.found_handle, got.found_handle);
          errors += field_bad("offset_in_entry", HANDLE_W'(want.offset_in_entry),
                              HANDLE_W'(got.offset_in_entry));
          errors += field_bad("dropped", HANDLE_W'(want.dropped), HANDLE_W'(got.dropped));
          errors += field_bad("dropped_handle", want.dropped_handle, got.dropped_handle);
        end
      end
    end
    pending <= owed_rsp.size();
  end

endmodule

// File: dv/ring_entry_offset_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// Ring entry offset lookup testbench
// Drives add and find requests with random gaps and response stalls, one
// long response hold-off, and leaves prediction and comparison to the
// checker. Directed requests hit empty, zero-length, boundary and overwrite
// cases; random phases vary entry sizes, request mix and pacing.
// ----------------------------------------------------------------------------
module ring_entry_offset_lookup_top_tb
  import reol_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 175;
  localparam int TAIL_CYCLES  = 40;

  typedef enum int {
    LEN_SHORT,
    LEN_BLEND,
    LEN_WIDE
  } len_mix_t;

  logic clk;
  logic rst_n;
  logic rsp_hold;
  logic hold_kick = 1'b0;
  int   rsp_stall_max = 9;
  int   req_gap_max = 9;
  int   lens_shadow [$];

  int errors;
  int pending;
  int adds_seen;
  int finds_seen;
  int hits_seen;
  int drops_seen;

  reol_req_if in_req ();
  reol_rsp_if out_rsp ();

  ring_entry_offset_lookup_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  reol_rsp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_req),
    .rsp_mon    (out_rsp),
    .errors     (errors),
    .pending    (pending),
    .adds_seen  (adds_seen),
    .finds_seen (finds_seen),
    .hits_seen  (hits_seen),
    .drops_seen (drops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ring_entry_offset_lookup_top_tb: done, errors");
    $finish;
  end

  initial begin : rsp_holdoff
    rsp_hold <= 1'b0;
    wait (hold_kick);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin : rsp_taker
    int wait_left;
    wait_left = 0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_rsp.valid && out_rsp.ready) wait_left = $urandom_range(0, rsp_stall_max);
      else if (wait_left > 0) wait_left--;
      out_rsp.ready <= rst_n && !rsp_hold && (wait_left == 0);
    end
  end

  function automatic int stream_bytes();
    int sum;
    sum = 0;
    foreach (lens_shadow[i]) sum += lens_shadow[i];
    return sum;
  endfunction

  function automatic logic [LEN_W-1:0] draw_len(input len_mix_t mix);
    int pick;
    pick = $urandom_range(0, 9);
    case (mix)
      LEN_SHORT: begin
        if (pick < 2) return '0;
        return LEN_W'($urandom_range(1, 32));
      end
      LEN_BLEND: begin
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick < 6) return LEN_W'($urandom_range(1, 255));
        return LEN_W'($urandom);
      end
      default: begin
        if (pick == 0) return '0;
        return LEN_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [POS_W-1:0] aim_pos();
    int total;
    int pick;
    int idx;
    int start;
    total = stream_bytes();
    pick  = $urandom_range(0, 9);
    if (pick == 8 || total == 0) return POS_W'($urandom);
    if (pick == 6) return POS_W'(total);
    if (pick == 7) return POS_W'(total - 1);
    if (pick == 9) begin
      idx   = $urandom_range(0, lens_shadow.size() - 1);
      start = 0;
      for (int i = 0; i < idx; i++) start += lens_shadow[i];
      return POS_W'(start);
    end
    return POS_W'($urandom_range(0, total - 1));
  endfunction

  task automatic push_req(input reol_req_t r);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= r;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic store_at(input logic [HANDLE_W-1:0] handle, input logic [LEN_W-1:0] len);
    reol_req_t r;
    r.req_type      = REQ_ADD;
    r.entry_handle  = handle;
    r.entry_length  = len;
    r.byte_position = POS_W'($urandom);
    lens_shadow.push_back(int'(len));
    if (lens_shadow.size() > RING_DEPTH_DEF) void'(lens_shadow.pop_front());
    push_req(r);
  endtask

  task automatic find_at(input logic [POS_W-1:0] pos);
    reol_req_t r;
    r.req_type      = REQ_FIND;
    r.entry_handle  = $urandom;
    r.entry_length  = LEN_W'($urandom);
    r.byte_position = pos;
    push_req(r);
  endtask

  initial begin : stimulus
    int       ph;
    int       n;
    int       find_pct;
    len_mix_t mix;
    in_req.valid <= 1'b0;
    in_req.data  <= '0;
    rst_n        <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    find_at('0);
    find_at('1);
    store_at(32'hFFFF_FFFF, 16'h0000);
    find_at('0);
    store_at(32'h0000_0000, 16'hFFFF);
    find_at(20'h00000);
    find_at(20'h0FFFE);
    find_at(20'h0FFFF);
    store_at(32'hA5A5_A5A5, 16'h0001);
    find_at(20'h0FFFF);
    find_at(20'h10000);
    for (n = 0; n < 13; n++) store_at($urandom, 16'hFFFF);
    store_at(32'h5A5A_5A5A, 16'hFFFF);
    find_at(POS_W'(stream_bytes() - 1));
    find_at('1);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          req_gap_max    = 9;
          rsp_stall_max <= 9;
          find_pct       = 50;
          mix            = LEN_SHORT;
        end
        1: begin
          req_gap_max    = 0;
          rsp_stall_max <= 0;
          find_pct       = 50;
          mix            = LEN_BLEND;
        end
        2: begin
          req_gap_max    = 0;
          rsp_stall_max <= 9;
          find_pct       = 40;
          mix            = LEN_WIDE;
          hold_kick     <= 1'b1;
        end
        default: begin
          req_gap_max    = 9;
          rsp_stall_max <= 3;
          find_pct       = 75;
          mix            = LEN_SHORT;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < find_pct) find_at(aim_pos());
        else store_at($urandom, draw_len(mix));
      end
    end

    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d adds (%0d overwrote the oldest entry) and %0d finds",
             adds_seen, drops_seen, finds_seen);
    $display("finds: %0d located an entry, %0d fell outside the stored bytes",
             hits_seen, finds_seen - hits_seen);
    if (errors == 0) begin
      $display("ring_entry_offset_lookup_top_tb: done, clean");
    end else begin
      $display("ring_entry_offset_lookup_top_tb: done, errors");
    end
    $finish;
  end

endmodule
